@@ hdl/half_pel_motion_compensation_assert.svh @@
// Assertion macros shared by the motion compensation modules.
// Each macro expects clk_i and rst_ni in the scope where it is used.
`ifndef HALF_PEL_MOTION_COMPENSATION_ASSERT_SVH
`define HALF_PEL_MOTION_COMPENSATION_ASSERT_SVH

// The consequent must hold in the same cycle as the antecedent.
`define HPMC_ASSERT_NOW(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("hpmc assertion failed");

// The consequent must hold in the cycle after the antecedent.
`define HPMC_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("hpmc assertion failed");

`endif

@@ hdl/hpmc_pkg.sv @@
`timescale 1ns / 1ps
package hpmc_pkg;

  localparam int POS_W     = 11;
  localparam int COORD_W   = POS_W + 1;
  localparam int SAMPLE_W  = 8;
  localparam int CFG_W     = 9;
  localparam int CFG_IDX_W = 2;

  localparam logic [CFG_IDX_W-1:0] CFG_PLANE_WIDTH  = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_PLANE_HEIGHT = 2'd1;
  localparam logic [CFG_W-1:0]     CFG_DIM_RESET    = 9'd256;

  localparam logic KIND_WRITE   = 1'b0;
  localparam logic KIND_PREDICT = 1'b1;

  typedef logic [SAMPLE_W-1:0] sample_t;

  typedef struct packed {
    logic valid;
    logic wr;
    logic hx;
    logic hy;
    logic avg;
    logic hit;
  } ctl_t;

endpackage

@@ hdl/hpmc_front.sv @@
`timescale 1ns / 1ps
`include "half_pel_motion_compensation_assert.svh"
module hpmc_front import hpmc_pkg::*; #(
  parameter int PLANE_W = 256,
  parameter int PLANE_H = 256
) (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       cfg_valid_i,
  input  logic [CFG_IDX_W-1:0]       cfg_index_i,
  input  logic [CFG_W-1:0]           cfg_data_i,
  input  logic                       in_valid_i,
  input  logic                       adv_i,
  input  logic                       kind_i,
  input  logic signed [POS_W-1:0]    pos_x_i,
  input  logic signed [POS_W-1:0]    pos_y_i,
  input  sample_t                    ref_value_i,
  input  logic                       half_x_i,
  input  logic                       half_y_i,
  input  logic                       average_i,
  input  sample_t                    prior_value_i,
  output ctl_t                       ctl_o,
  output logic [$clog2(PLANE_W)-1:0] col0_o,
  output logic [$clog2(PLANE_W)-1:0] col1_o,
  output logic [$clog2(PLANE_H)-1:0] row0_o,
  output logic [$clog2(PLANE_H)-1:0] row1_o,
  output sample_t                    ref_o,
  output sample_t                    prior_o
);

  localparam int COL_W = $clog2(PLANE_W);
  localparam int ROW_W = $clog2(PLANE_H);
  localparam logic [COORD_W-1:0] W_MAX = COORD_W'(PLANE_W);
  localparam logic [COORD_W-1:0] H_MAX = COORD_W'(PLANE_H);

  function automatic logic [COORD_W-1:0] clamp_fn(input logic [COORD_W-1:0] v,
                                                  input logic [COORD_W-1:0] dim);
    if (v[COORD_W-1]) return '0;
    if (v >= dim) return dim - COORD_W'(1);
    return v;
  endfunction

  function automatic logic outside_fn(input logic [COORD_W-1:0] v,
                                      input logic [COORD_W-1:0] dim);
    return v[COORD_W-1] || (v >= dim);
  endfunction

  function automatic logic [COORD_W-1:0] eff_dim_fn(input logic [CFG_W-1:0] r,
                                                    input logic [COORD_W-1:0] lim);
    if (r == '0) return COORD_W'(1);
    if (COORD_W'(r) > lim) return lim;
    return COORD_W'(r);
  endfunction

  logic [CFG_W-1:0]   width_q, height_q;
  logic [COORD_W-1:0] w_eff, h_eff;
  logic [COORD_W-1:0] x0, x1, y0, y1;
  logic [COORD_W-1:0] cx0, cx1, cy0, cy1;
  logic               is_wr, in_plane, hit;
  ctl_t               ctl_d, ctl_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      width_q  <= CFG_DIM_RESET;
      height_q <= CFG_DIM_RESET;
    end else if (cfg_valid_i) begin
      case (cfg_index_i)
        CFG_PLANE_WIDTH:  width_q  <= cfg_data_i;
        CFG_PLANE_HEIGHT: height_q <= cfg_data_i;
        default: ;
      endcase
    end
  end

  assign w_eff = eff_dim_fn(width_q, W_MAX);
  assign h_eff = eff_dim_fn(height_q, H_MAX);

  assign x0 = {pos_x_i[POS_W-1], pos_x_i};
  assign y0 = {pos_y_i[POS_W-1], pos_y_i};
  assign x1 = x0 + COORD_W'(1);
  assign y1 = y0 + COORD_W'(1);

  assign cx0 = clamp_fn(x0, w_eff);
  assign cx1 = clamp_fn(x1, w_eff);
  assign cy0 = clamp_fn(y0, h_eff);
  assign cy1 = clamp_fn(y1, h_eff);

  assign is_wr    = (kind_i == KIND_WRITE);
  assign in_plane = !outside_fn(x0, w_eff) && !outside_fn(y0, h_eff);
  assign hit      = outside_fn(x0, w_eff) || outside_fn(y0, h_eff) ||
                    (half_x_i && outside_fn(x1, w_eff)) ||
                    (half_y_i && outside_fn(y1, h_eff));

  always_comb begin
    ctl_d.valid = in_valid_i && (!is_wr || in_plane);
    ctl_d.wr    = is_wr;
    ctl_d.hx    = half_x_i;
    ctl_d.hy    = half_y_i;
    ctl_d.avg   = average_i;
    ctl_d.hit   = hit;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ctl_q <= '0;
    end else if (adv_i) begin
      ctl_q <= ctl_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv_i) begin
      col0_o  <= cx0[COL_W-1:0];
      col1_o  <= is_wr ? cx0[COL_W-1:0] : cx1[COL_W-1:0];
      row0_o  <= cy0[ROW_W-1:0];
      row1_o  <= is_wr ? cy0[ROW_W-1:0] : cy1[ROW_W-1:0];
      ref_o   <= ref_value_i;
      prior_o <= prior_value_i;
    end
  end

  assign ctl_o = ctl_q;

  `HPMC_ASSERT_NEXT(a_neg_write_dropped, in_valid_i && adv_i && (kind_i == KIND_WRITE) && pos_x_i[POS_W-1], !ctl_q.valid)

endmodule

@@ hdl/hpmc_plane.sv @@
`timescale 1ns / 1ps
`include "half_pel_motion_compensation_assert.svh"
module hpmc_plane import hpmc_pkg::*; #(
  parameter int PLANE_W = 256,
  parameter int PLANE_H = 256
) (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       adv_i,
  input  ctl_t                       ctl_i,
  input  logic [$clog2(PLANE_W)-1:0] col0_i,
  input  logic [$clog2(PLANE_W)-1:0] col1_i,
  input  logic [$clog2(PLANE_H)-1:0] row0_i,
  input  logic [$clog2(PLANE_H)-1:0] row1_i,
  input  sample_t                    wdata_i,
  input  sample_t                    prior_i,
  output ctl_t                       ctl_o,
  output sample_t                    prior_o,
  output sample_t                    a_o,
  output sample_t                    b_o,
  output sample_t                    c_o,
  output sample_t                    e_o
);

  localparam int COL_W = $clog2(PLANE_W);
  localparam int ROW_W = $clog2(PLANE_H);
  localparam int BW    = (PLANE_W + 1) / 2;
  localparam int BH    = (PLANE_H + 1) / 2;
  localparam int DEPTH = BW * BH;
  localparam int AW    = $clog2(DEPTH);

  logic [3:0]               bank_we;
  logic [3:0][SAMPLE_W-1:0] rd;
  ctl_t                     ctl_q;
  logic                     px0_q, px1_q, py0_q, py1_q;

  for (genvar gb = 0; gb < 4; gb++) begin : g_bank
    localparam logic PX = 1'(gb % 2);
    localparam logic PY = 1'(gb / 2);

    logic [SAMPLE_W-1:0] mem [DEPTH];
    logic [SAMPLE_W-1:0] rd_q;
    logic [COL_W-1:0]    col;
    logic [ROW_W-1:0]    row;
    logic [AW-1:0]       addr;

    assign col  = (col0_i[0] == PX) ? col0_i : col1_i;
    assign row  = (row0_i[0] == PY) ? row0_i : row1_i;
    assign addr = AW'(row[ROW_W-1:1]) * AW'(BW) + AW'(col[COL_W-1:1]);

    assign bank_we[gb] = adv_i && ctl_i.valid && ctl_i.wr &&
                         (col0_i[0] == PX) && (row0_i[0] == PY);

    always_ff @(posedge clk_i) begin
      if (bank_we[gb]) begin
        mem[addr] <= wdata_i;
      end
      if (adv_i) begin
        rd_q <= mem[addr];
      end
    end

    assign rd[gb] = rd_q;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ctl_q <= '0;
    end else if (adv_i) begin
      ctl_q <= ctl_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv_i) begin
      px0_q   <= col0_i[0];
      px1_q   <= col1_i[0];
      py0_q   <= row0_i[0];
      py1_q   <= row1_i[0];
      prior_o <= prior_i;
    end
  end

  assign ctl_o = ctl_q;
  assign a_o   = rd[{py0_q, px0_q}];
  assign b_o   = rd[{py0_q, px1_q}];
  assign c_o   = rd[{py1_q, px0_q}];
  assign e_o   = rd[{py1_q, px1_q}];

  `HPMC_ASSERT_NOW(a_write_one_bank, adv_i && ctl_i.valid && ctl_i.wr, $onehot(bank_we))
  `HPMC_ASSERT_NOW(a_no_stray_write, !(adv_i && ctl_i.valid && ctl_i.wr), bank_we == '0)

endmodule

@@ hdl/hpmc_filter.sv @@
`timescale 1ns / 1ps
`include "half_pel_motion_compensation_assert.svh"
module hpmc_filter import hpmc_pkg::*; (
  input  logic    clk_i,
  input  logic    rst_ni,
  input  ctl_t    ctl_i,
  input  sample_t prior_i,
  input  sample_t a_i,
  input  sample_t b_i,
  input  sample_t c_i,
  input  sample_t e_i,
  input  logic    out_stall_i,
  output logic    adv_o,
  output logic    out_valid_o,
  output sample_t pred_value_o,
  output logic    clamped_o
);

  localparam logic [1:0] HALF_NONE = 2'b00;
  localparam logic [1:0] HALF_Y    = 2'b01;
  localparam logic [1:0] HALF_X    = 2'b10;
  localparam logic [1:0] HALF_XY   = 2'b11;

  logic [SAMPLE_W:0]   sum_ab, sum_ac, sum_avg;
  logic [SAMPLE_W+1:0] sum4;
  sample_t             interp, pred_d;
  logic                out_valid_q;

  assign sum_ab = (SAMPLE_W+1)'(a_i) + (SAMPLE_W+1)'(b_i) + (SAMPLE_W+1)'(1);
  assign sum_ac = (SAMPLE_W+1)'(a_i) + (SAMPLE_W+1)'(c_i) + (SAMPLE_W+1)'(1);
  assign sum4   = (SAMPLE_W+2)'(a_i) + (SAMPLE_W+2)'(b_i) + (SAMPLE_W+2)'(c_i) +
                  (SAMPLE_W+2)'(e_i) + (SAMPLE_W+2)'(2);

  always_comb begin
    case ({ctl_i.hx, ctl_i.hy})
      HALF_NONE: interp = a_i;
      HALF_X:    interp = sum_ab[SAMPLE_W:1];
      HALF_Y:    interp = sum_ac[SAMPLE_W:1];
      HALF_XY:   interp = sum4[SAMPLE_W+1:2];
      default:   interp = a_i;
    endcase
  end

  assign sum_avg = (SAMPLE_W+1)'(prior_i) + (SAMPLE_W+1)'(interp) + (SAMPLE_W+1)'(1);
  assign pred_d  = ctl_i.avg ? sum_avg[SAMPLE_W:1] : interp;

  assign adv_o = !out_valid_q || !out_stall_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (adv_o) begin
      out_valid_q <= ctl_i.valid && !ctl_i.wr;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv_o) begin
      pred_value_o <= pred_d;
      clamped_o    <= ctl_i.hit;
    end
  end

  assign out_valid_o = out_valid_q;

  `HPMC_ASSERT_NEXT(a_predict_reaches_out, adv_o && ctl_i.valid && !ctl_i.wr, out_valid_q)
  `HPMC_ASSERT_NEXT(a_full_pel_passes, adv_o && ctl_i.valid && !ctl_i.wr && !ctl_i.hx && !ctl_i.hy && !ctl_i.avg, pred_value_o == $past(a_i))

endmodule

@@ hdl/half_pel_motion_compensation.sv @@
// Half-pel motion compensation, one sample per beat.
// Input channel (in_valid_i / in_stall_o): a write beat (kind_i = 0) stores ref_value_i
// at (pos_x_i, pos_y_i) when that point lies inside the configured plane; otherwise
// it is dropped. A predict beat (kind_i = 1) fetches up to four neighbours with
// coordinates clamped into the plane, forms the round-up average, optionally
// averages again with prior_value_i, and returns one output beat.
// Output channel (out_valid_o / out_stall_i): pred_value_o and clamped_o.
// Configuration (cfg_valid_i / cfg_ready_o): index 0 sets the plane width, index 1
// the plane height; other indexes are ignored. Write it only while the block is idle.
// A predict passes the front, plane and filter registers before out_valid_o rises.
// Throughput: one beat per cycle unless the output stalls; four parity banks supply
// all neighbours in a single read, and one beat's write and the next's reads never collide.
// When the output register is full and stalled, the whole pipeline holds and
// in_stall_o is raised; otherwise beats keep flowing.
// Reset clears the pipeline valid bits and sets both plane sizes to 256; the sample
// memory is not cleared, and predicts must only touch samples already written.
`timescale 1ns / 1ps
module half_pel_motion_compensation import hpmc_pkg::*; #(
  parameter int PLANE_W = 256,
  parameter int PLANE_H = 256
) (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  logic                    cfg_valid_i,
  output logic                    cfg_ready_o,
  input  logic [CFG_IDX_W-1:0]    cfg_index_i,
  input  logic [CFG_W-1:0]        cfg_data_i,
  input  logic                    in_valid_i,
  output logic                    in_stall_o,
  input  logic                    kind_i,
  input  logic signed [POS_W-1:0] pos_x_i,
  input  logic signed [POS_W-1:0] pos_y_i,
  input  logic [SAMPLE_W-1:0]     ref_value_i,
  input  logic                    half_x_i,
  input  logic                    half_y_i,
  input  logic                    average_i,
  input  logic [SAMPLE_W-1:0]     prior_value_i,
  output logic                    out_valid_o,
  input  logic                    out_stall_i,
  output logic [SAMPLE_W-1:0]     pred_value_o,
  output logic                    clamped_o
);

  localparam int COL_W = $clog2(PLANE_W);
  localparam int ROW_W = $clog2(PLANE_H);

  logic             adv;
  ctl_t             s1_ctl, s2_ctl;
  logic [COL_W-1:0] s1_col0, s1_col1;
  logic [ROW_W-1:0] s1_row0, s1_row1;
  sample_t          s1_ref, s1_prior, s2_prior;
  sample_t          s2_a, s2_b, s2_c, s2_e;

  assign cfg_ready_o = 1'b1;
  assign in_stall_o  = !adv;

  hpmc_front #(
    .PLANE_W(PLANE_W),
    .PLANE_H(PLANE_H)
  ) u_front (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_valid_i  (cfg_valid_i),
    .cfg_index_i  (cfg_index_i),
    .cfg_data_i   (cfg_data_i),
    .in_valid_i   (in_valid_i),
    .adv_i        (adv),
    .kind_i       (kind_i),
    .pos_x_i      (pos_x_i),
    .pos_y_i      (pos_y_i),
    .ref_value_i  (ref_value_i),
    .half_x_i     (half_x_i),
    .half_y_i     (half_y_i),
    .average_i    (average_i),
    .prior_value_i(prior_value_i),
    .ctl_o        (s1_ctl),
    .col0_o       (s1_col0),
    .col1_o       (s1_col1),
    .row0_o       (s1_row0),
    .row1_o       (s1_row1),
    .ref_o        (s1_ref),
    .prior_o      (s1_prior)
  );

  hpmc_plane #(
    .PLANE_W(PLANE_W),
    .PLANE_H(PLANE_H)
  ) u_plane (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .adv_i  (adv),
    .ctl_i  (s1_ctl),
    .col0_i (s1_col0),
    .col1_i (s1_col1),
    .row0_i (s1_row0),
    .row1_i (s1_row1),
    .wdata_i(s1_ref),
    .prior_i(s1_prior),
    .ctl_o  (s2_ctl),
    .prior_o(s2_prior),
    .a_o    (s2_a),
    .b_o    (s2_b),
    .c_o    (s2_c),
    .e_o    (s2_e)
  );

  hpmc_filter u_filter (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .ctl_i       (s2_ctl),
    .prior_i     (s2_prior),
    .a_i         (s2_a),
    .b_i         (s2_b),
    .c_i         (s2_c),
    .e_i         (s2_e),
    .out_stall_i (out_stall_i),
    .adv_o       (adv),
    .out_valid_o (out_valid_o),
    .pred_value_o(pred_value_o),
    .clamped_o   (clamped_o)
  );

endmodule

@@ tb/half_pel_motion_compensation_test.sv @@
`timescale 1ns / 1ps
module half_pel_motion_compensation_test;
  import hpmc_pkg::*;

  localparam int PLANE_W = 256;
  localparam int PLANE_H = 256;
  localparam int IDLE_PCT = 16;
  localparam int LONG_HOLD = 150;
  localparam int SETTLE = 6;
  localparam int LIMIT = 200000;
  localparam int MAX_PRINTS = 40;
  localparam logic [CFG_IDX_W-1:0] CFG_SPARE_LO = 2'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_SPARE_HI = 2'd3;

  typedef struct {
    logic                    kind;
    logic signed [POS_W-1:0] x;
    logic signed [POS_W-1:0] y;
    sample_t                 ref_value;
    logic                    hx;
    logic                    hy;
    logic                    avg;
    sample_t                 prior;
  } mc_beat_t;

  typedef struct {
    sample_t value;
    logic    clamped;
  } mc_pred_t;

  logic                 clk_i = 1'b0;
  logic                 rst_ni = 1'b0;
  logic                 cfg_valid = 1'b0;
  logic                 cfg_ready;
  logic [CFG_IDX_W-1:0] cfg_index = '0;
  logic [CFG_W-1:0]     cfg_data = '0;
  logic                 in_valid = 1'b0;
  logic                 in_stall;
  logic                 out_valid;
  logic                 out_stall = 1'b0;
  sample_t              pred_value;
  logic                 clamped;

  logic quiet = 1'b0;
  logic hold_request = 1'b0;
  int   hold_left = 0;
  int   beats_in = 0;
  int   errors = 0;
  int   cycles = 0;
  int   gen_count = 0;

  mc_beat_t sent_beat = '{default: '0};
  mc_beat_t next_beat;
  mc_pred_t want_pred;
  mc_beat_t pending_beats[$];
  mc_pred_t predicted_samples[$];

  logic [CFG_W-1:0] width_reg = CFG_DIM_RESET;
  logic [CFG_W-1:0] height_reg = CFG_DIM_RESET;
  sample_t          plane_mem[PLANE_W*PLANE_H];
  bit               filled[PLANE_W*PLANE_H];

  half_pel_motion_compensation #(
    .PLANE_W(PLANE_W),
    .PLANE_H(PLANE_H)
  ) u_dut (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_valid_i  (cfg_valid),
    .cfg_ready_o  (cfg_ready),
    .cfg_index_i  (cfg_index),
    .cfg_data_i   (cfg_data),
    .in_valid_i   (in_valid),
    .in_stall_o   (in_stall),
    .kind_i       (sent_beat.kind),
    .pos_x_i      (sent_beat.x),
    .pos_y_i      (sent_beat.y),
    .ref_value_i  (sent_beat.ref_value),
    .half_x_i     (sent_beat.hx),
    .half_y_i     (sent_beat.hy),
    .average_i    (sent_beat.avg),
    .prior_value_i(sent_beat.prior),
    .out_valid_o  (out_valid),
    .out_stall_i  (out_stall),
    .pred_value_o (pred_value),
    .clamped_o    (clamped)
  );

  initial begin
    forever #5 clk_i = ~clk_i;
  end

  function automatic int eff_dim(logic [CFG_W-1:0] r, int limit);
    if (r == '0) return 1;
    if (int'(r) > limit) return limit;
    return int'(r);
  endfunction

  function automatic int clip(int v, int size);
    if (v < 0) return 0;
    if (v >= size) return size - 1;
    return v;
  endfunction

  function automatic mc_pred_t interpolate(mc_beat_t b);
    int w, h, x, y, cx, cy, nx, ny, dx, dy, sum, p;
    mc_pred_t r;
    w = eff_dim(width_reg, PLANE_W);
    h = eff_dim(height_reg, PLANE_H);
    x = int'(b.x);
    y = int'(b.y);
    nx = b.hx ? 2 : 1;
    ny = b.hy ? 2 : 1;
    sum = 0;
    r.clamped = 1'b0;
    for (dy = 0; dy < ny; dy++) begin
      for (dx = 0; dx < nx; dx++) begin
        cx = clip(x + dx, w);
        cy = clip(y + dy, h);
        if (cx != x + dx || cy != y + dy) r.clamped = 1'b1;
        sum += int'(plane_mem[cy * PLANE_W + cx]);
      end
    end
    if (nx * ny == 1) p = sum;
    else if (nx * ny == 2) p = (sum + 1) >> 1;
    else p = (sum + 2) >> 2;
    if (b.avg) p = (int'(b.prior) + p + 1) >> 1;
    r.value = p[SAMPLE_W-1:0];
    return r;
  endfunction

  task automatic apply_beat(mc_beat_t b);
    int x, y;
    x = int'(b.x);
    y = int'(b.y);
    if (b.kind == KIND_WRITE) begin
      if (x >= 0 && x < eff_dim(width_reg, PLANE_W) && y >= 0 &&
          y < eff_dim(height_reg, PLANE_H)) begin
        plane_mem[y * PLANE_W + x] = b.ref_value;
      end
    end else begin
      predicted_samples.push_back(interpolate(b));
    end
  endtask

  task automatic report_mismatch(string what, int got, int want);
    if (errors < MAX_PRINTS) begin
      $display("mismatch on %s: got %0d, expected %0d at %0t", what, got, want, $realtime);
    end
    errors++;
  endtask

  task automatic queue_write(int x, int y, int v);
    mc_beat_t b;
    b.kind = KIND_WRITE;
    b.x = x[POS_W-1:0];
    b.y = y[POS_W-1:0];
    b.ref_value = v[SAMPLE_W-1:0];
    b.hx = 1'($urandom_range(1));
    b.hy = 1'($urandom_range(1));
    b.avg = 1'($urandom_range(1));
    b.prior = SAMPLE_W'($urandom_range(255));
    pending_beats.push_back(b);
    if (x >= 0 && x < eff_dim(width_reg, PLANE_W) && y >= 0 &&
        y < eff_dim(height_reg, PLANE_H)) begin
      filled[y * PLANE_W + x] = 1'b1;
      gen_count++;
    end
  endtask

  // Every sample the predict will fetch is written first if it never was.
  task automatic queue_predict(int x, int y, bit hx, bit hy, bit avg, int prior);
    mc_beat_t b;
    int w, h, dx, dy, cx, cy;
    w = eff_dim(width_reg, PLANE_W);
    h = eff_dim(height_reg, PLANE_H);
    for (dy = 0; dy <= int'(hy); dy++) begin
      for (dx = 0; dx <= int'(hx); dx++) begin
        cx = clip(x + dx, w);
        cy = clip(y + dy, h);
        if (!filled[cy * PLANE_W + cx]) queue_write(cx, cy, $urandom_range(255));
      end
    end
    b.kind = KIND_PREDICT;
    b.x = x[POS_W-1:0];
    b.y = y[POS_W-1:0];
    b.ref_value = SAMPLE_W'($urandom_range(255));
    b.hx = hx;
    b.hy = hy;
    b.avg = avg;
    b.prior = prior[SAMPLE_W-1:0];
    pending_beats.push_back(b);
    gen_count++;
  endtask

  task automatic queue_random(int n);
    int target, sel, w, h;
    target = gen_count + n;
    w = eff_dim(width_reg, PLANE_W);
    h = eff_dim(height_reg, PLANE_H);
    while (gen_count < target) begin
      sel = $urandom_range(99);
      if (sel < 55) begin
        queue_predict($urandom_range(w + 3) - 2, $urandom_range(h + 3) - 2,
                      1'($urandom_range(1)), 1'($urandom_range(1)),
                      1'($urandom_range(1)), $urandom_range(255));
      end else if (sel < 65) begin
        queue_predict($urandom_range(2047) - 1024, $urandom_range(2047) - 1024,
                      1'($urandom_range(1)), 1'($urandom_range(1)),
                      1'($urandom_range(1)), $urandom_range(255));
      end else if (sel < 90) begin
        queue_write($urandom_range(w - 1), $urandom_range(h - 1), $urandom_range(255));
      end else begin
        queue_write($urandom_range(2047) - 1024, $urandom_range(2047) - 1024,
                    $urandom_range(255));
      end
    end
  endtask

  // The check runs between rising edges, after the driver and monitor have settled.
  task automatic settle();
    do @(negedge clk_i);
    while (pending_beats.size() != 0 || in_valid || predicted_samples.size() != 0);
    repeat (SETTLE) @(posedge clk_i);
  endtask

  task automatic write_register(logic [CFG_IDX_W-1:0] idx, int value);
    @(posedge clk_i);
    cfg_index <= idx;
    cfg_data <= value[CFG_W-1:0];
    cfg_valid <= 1'b1;
    do @(posedge clk_i);
    while (!cfg_ready);
    cfg_valid <= 1'b0;
    if (idx == CFG_PLANE_WIDTH) width_reg = value[CFG_W-1:0];
    else if (idx == CFG_PLANE_HEIGHT) height_reg = value[CFG_W-1:0];
  endtask

  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (in_valid && !in_stall) begin
        apply_beat(sent_beat);
        beats_in <= beats_in + 1;
      end
      if (!in_valid || !in_stall) begin
        if (pending_beats.size() != 0 && (quiet || $urandom_range(99) >= IDLE_PCT)) begin
          next_beat = pending_beats.pop_front();
          sent_beat <= next_beat;
          in_valid <= 1'b1;
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (out_valid && !out_stall) begin
        if (predicted_samples.size() == 0) begin
          report_mismatch("beat with no prediction pending", int'(pred_value), -1);
        end else begin
          want_pred = predicted_samples.pop_front();
          if (pred_value !== want_pred.value) begin
            report_mismatch("pred_value", int'(pred_value), int'(want_pred.value));
          end
          if (clamped !== want_pred.clamped) begin
            report_mismatch("clamped", int'(clamped), int'(want_pred.clamped));
          end
        end
      end
      if (hold_left != 0) begin
        out_stall <= 1'b1;
        hold_left <= hold_left - 1;
      end else if (hold_request) begin
        out_stall <= 1'b1;
        hold_left <= LONG_HOLD;
      end else begin
        out_stall <= !quiet && ($urandom_range(99) < IDLE_PCT);
      end
    end
  end

  always @(posedge clk_i) begin
    cycles <= cycles + 1;
    if (cycles >= LIMIT) begin
      $display("end of test: mismatches");
      $finish;
    end
  end

  initial begin
    int hold_mark;
    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;

    queue_write(0, 0, 255);
    queue_write(1, 0, 255);
    queue_write(0, 1, 255);
    queue_write(1, 1, 254);
    queue_write(255, 255, 0);
    queue_write(254, 255, 1);
    queue_write(PLANE_W, 0, 7);
    queue_write(-1, 5, 9);
    queue_write(-1024, -1024, 3);
    queue_write(1023, 1023, 4);
    queue_predict(0, 0, 1'b0, 1'b0, 1'b0, 0);
    queue_predict(0, 0, 1'b1, 1'b0, 1'b0, 0);
    queue_predict(0, 0, 1'b0, 1'b1, 1'b0, 0);
    queue_predict(0, 0, 1'b1, 1'b1, 1'b0, 0);
    queue_predict(0, 0, 1'b1, 1'b1, 1'b1, 255);
    queue_predict(1, 1, 1'b1, 1'b1, 1'b1, 0);
    queue_predict(255, 255, 1'b1, 1'b1, 1'b0, 0);
    queue_predict(254, 255, 1'b1, 1'b0, 1'b1, 128);
    queue_predict(-1024, -1024, 1'b1, 1'b1, 1'b0, 0);
    queue_predict(1023, 1023, 1'b0, 1'b0, 1'b1, 255);
    queue_predict(-1, 0, 1'b0, 1'b1, 1'b0, 0);
    settle();

    write_register(CFG_PLANE_WIDTH, 0);
    write_register(CFG_PLANE_HEIGHT, 0);
    queue_random(40);
    settle();

    write_register(CFG_PLANE_WIDTH, 1);
    write_register(CFG_PLANE_HEIGHT, 511);
    queue_random(60);
    settle();

    write_register(CFG_PLANE_WIDTH, 511);
    write_register(CFG_PLANE_HEIGHT, 2);
    queue_random(60);
    settle();

    write_register(CFG_SPARE_LO, $urandom_range(511));
    write_register(CFG_SPARE_HI, $urandom_range(511));
    write_register(CFG_PLANE_WIDTH, 256);
    write_register(CFG_PLANE_HEIGHT, 256);
    queue_random(450);
    hold_mark = beats_in + 100;
    do @(posedge clk_i);
    while (beats_in < hold_mark);
    hold_request <= 1'b1;
    @(posedge clk_i);
    hold_request <= 1'b0;
    settle();
    queue_random(150);
    settle();

    write_register(CFG_PLANE_WIDTH, $urandom_range(2, 40));
    write_register(CFG_PLANE_HEIGHT, $urandom_range(2, 40));
    quiet <= 1'b1;
    queue_random(200);
    settle();
    quiet <= 1'b0;

    write_register(CFG_PLANE_WIDTH, $urandom_range(511));
    write_register(CFG_PLANE_HEIGHT, $urandom_range(511));
    queue_random(200);
    settle();

    write_register(CFG_PLANE_WIDTH, 16);
    write_register(CFG_PLANE_HEIGHT, 16);
    queue_random(150);
    settle();

    if (errors == 0 && predicted_samples.size() == 0) begin
      $display("end of test: clean");
    end else begin
      $display("end of test: mismatches");
    end
    $finish;
  end

endmodule
